>>> rtl/hrrn_pkg.sv
package hrrn_pkg;

  localparam int MAX_PENDING = 16;
  localparam int IDX_W       = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int ID_W        = 8;
  localparam int TIME_W      = 32;
  localparam int PROD_W      = 2 * TIME_W;

  typedef struct packed {
    logic sel_pb;
    logic load_pa;
    logic load_pb;
  } ratio_ctl_t;

endpackage

>>> rtl/hrrn_ratio_unit.sv
module hrrn_ratio_unit (
  input  logic                      clk,
  input  hrrn_pkg::ratio_ctl_t      ctl,
  input  logic [hrrn_pkg::TIME_W-1:0] cand_mag,
  input  logic [hrrn_pkg::TIME_W-1:0] cand_left,
  input  logic [hrrn_pkg::TIME_W-1:0] best_mag,
  input  logic [hrrn_pkg::TIME_W-1:0] best_left,
  input  logic                      neg,
  output logic                      beats
);
  import hrrn_pkg::*;

  logic [TIME_W-1:0] mx;
  logic [TIME_W-1:0] my;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] pa_r;
  logic [PROD_W-1:0] pb_r;

  // pa = wait_cand * left_best, pb = wait_best * left_cand
  assign mx   = ctl.sel_pb ? best_mag  : cand_mag;
  assign my   = ctl.sel_pb ? cand_left : best_left;
  assign prod = PROD_W'(mx) * PROD_W'(my);

  always_ff @(posedge clk) begin
    if (ctl.load_pa) pa_r <= prod;
    if (ctl.load_pb) pb_r <= prod;
  end

  assign beats = neg ? (pa_r < pb_r) : (pa_r > pb_r);

endmodule

>>> rtl/hrrn_process_scheduler.sv
// Non-preemptive highest-response-ratio-next scheduler. Each input word is a
// tick (func 0) or an arrival (func 1); every word returns exactly one result
// word with the running process and the arrival drop flag. An arrival, or a
// tick while the current process still has time left, is answered straight
// from the idle state. A tick that needs a new pick walks all MAX_PENDING
// slots through one shared 32x32 cross-multiply unit: empty slots are
// skipped, the first occupied slot becomes the best, and each further
// occupied slot is decided by sign when its wait and the best wait differ in
// sign, or by two multiplies and a compare when they share it. The walk is
// framed by setup and writeback, and the result waits while the output is
// stalled. The input stalls while a pick is in progress.
module hrrn_process_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_proc_id,
  input  logic [31:0] in_start_time,
  input  logic [31:0] in_run_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic [31:0] out_running_left,
  output logic        out_arrival_dropped
);
  import hrrn_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_EVAL = 8'b0000_0100,
    S_MUL1 = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] left;
  } slot_t;

  state_t                 state_r;
  logic [MAX_PENDING-1:0] slot_valid_r;
  slot_t                  slot_mem [MAX_PENDING];
  slot_t                  rd_r;

  logic [IDX_W-1:0]  idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [ID_W-1:0]   best_id_r;
  logic [TIME_W-1:0] best_mag_r;
  logic [TIME_W-1:0] best_left_r;
  logic              best_neg_r;
  logic [ID_W-1:0]   cand_id_r;
  logic [TIME_W-1:0] cand_mag_r;
  logic [TIME_W-1:0] cand_left_r;
  logic              cand_neg_r;

  logic              run_valid_r;
  logic [ID_W-1:0]   run_id_r;
  logic [TIME_W-1:0] run_left_r;
  logic [TIME_W-1:0] tick_count_r;

  logic              out_valid_r;
  logic              out_run_valid_r;
  logic [ID_W-1:0]   out_run_id_r;
  logic [TIME_W-1:0] out_run_left_r;
  logic              out_dropped_r;

  logic              in_acc;
  logic              out_free;
  logic              pick_due;
  logic              store_ok;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              last_idx;
  logic              w_ge;
  logic              w_neg;
  logic [TIME_W-1:0] w_mag;
  logic              beats;
  ratio_ctl_t        rctl;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign pick_due = !run_valid_r || (run_left_r == '0);
  assign last_idx = (idx_r == IDX_W'(MAX_PENDING - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_PENDING - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign store_ok = (in_run_time != '0) && free_found;

  // signed wait of the slot just read, as sign and magnitude
  assign w_ge  = tick_count_r >= rd_r.start;
  assign w_mag = w_ge ? (tick_count_r - rd_r.start) : (rd_r.start - tick_count_r);
  assign w_neg = !w_ge;

  always_ff @(posedge clk) begin
    if (in_acc && in_func && store_ok) begin
      slot_mem[free_idx] <= '{id: in_proc_id, start: in_start_time, left: in_run_time};
    end
    rd_r <= slot_mem[idx_r];
  end

  assign rctl.sel_pb  = (state_r == S_MUL2);
  assign rctl.load_pa = (state_r == S_MUL1);
  assign rctl.load_pb = (state_r == S_MUL2);

  hrrn_ratio_unit u_ratio (
    .clk       (clk),
    .ctl       (rctl),
    .cand_mag  (cand_mag_r),
    .cand_left (cand_left_r),
    .best_mag  (best_mag_r),
    .best_left (best_left_r),
    .neg       (cand_neg_r),
    .beats     (beats)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      run_valid_r  <= 1'b0;
      run_id_r     <= '0;
      run_left_r   <= '0;
      tick_count_r <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_func) begin
              if (store_ok) slot_valid_r[free_idx] <= 1'b1;
              out_valid_r     <= 1'b1;
              out_run_valid_r <= run_valid_r;
              out_run_id_r    <= run_id_r;
              out_run_left_r  <= run_left_r;
              out_dropped_r   <= !store_ok;
            end else if (pick_due) begin
              idx_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_RD;
            end else begin
              run_left_r      <= run_left_r - 1'b1;
              tick_count_r    <= tick_count_r + 1'b1;
              out_valid_r     <= 1'b1;
              out_run_valid_r <= run_valid_r;
              out_run_id_r    <= run_id_r;
              out_run_left_r  <= run_left_r - 1'b1;
              out_dropped_r   <= 1'b0;
            end
          end
        end
        S_RD: begin
          if (slot_valid_r[idx_r]) begin
            state_r <= S_EVAL;
          end else if (last_idx) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EVAL: begin
          cand_id_r   <= rd_r.id;
          cand_mag_r  <= w_mag;
          cand_left_r <= rd_r.left;
          cand_neg_r  <= w_neg;
          if (!found_r || (w_neg != best_neg_r)) begin
            if (!found_r || best_neg_r) begin
              found_r     <= 1'b1;
              best_idx_r  <= idx_r;
              best_id_r   <= rd_r.id;
              best_mag_r  <= w_mag;
              best_left_r <= rd_r.left;
              best_neg_r  <= w_neg;
            end
            if (last_idx) begin
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_CMP;
        S_CMP: begin
          if (beats) begin
            best_idx_r  <= idx_r;
            best_id_r   <= cand_id_r;
            best_mag_r  <= cand_mag_r;
            best_left_r <= cand_left_r;
            best_neg_r  <= cand_neg_r;
          end
          if (last_idx) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (found_r) begin
            run_valid_r              <= 1'b1;
            run_id_r                 <= best_id_r;
            run_left_r               <= best_left_r - 1'b1;
            slot_valid_r[best_idx_r] <= 1'b0;
          end else begin
            run_valid_r <= 1'b0;
            run_id_r    <= '0;
            run_left_r  <= '0;
          end
          tick_count_r <= tick_count_r + 1'b1;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_run_valid_r <= run_valid_r;
            out_run_id_r    <= run_id_r;
            out_run_left_r  <= run_left_r;
            out_dropped_r   <= 1'b0;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_running_valid   = out_run_valid_r;
  assign out_running_id      = out_run_id_r;
  assign out_running_left    = out_run_left_r;
  assign out_arrival_dropped = out_dropped_r;

`ifndef NO_ASSERTIONS
  a_idle_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !run_valid_r |-> (run_id_r == '0) && (run_left_r == '0))
    else $error("idle processor holds stale id or time");

  a_mul_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> found_r)
    else $error("ratio compare without a current best");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken during a pick");

  a_done_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (tick_count_r == $past(tick_count_r) + 1'b1))
    else $error("tick counter not advanced after a pick");
`endif

endmodule
